>>> design/jsh_pkg.sv
`timescale 1ns / 1ps

package jsh_pkg;

    typedef enum logic [2:0] {
        PH_SOI0,
        PH_SOI1,
        PH_MARK1,
        PH_MARK2,
        PH_LENH,
        PH_LENL,
        PH_BODY,
        PH_STOP
    } t_phase;

    localparam logic [2:0] EV_NOT_JPEG   = 3'd0;
    localparam logic [2:0] EV_MARKER     = 3'd1;
    localparam logic [2:0] EV_FRAME_SIZE = 3'd2;
    localparam logic [2:0] EV_DENSITY    = 3'd3;
    localparam logic [2:0] EV_COMMENT    = 3'd4;
    localparam logic [2:0] EV_BAD_PREFIX = 3'd5;

    localparam logic [7:0] MK_PREFIX = 8'hFF;
    localparam logic [7:0] MK_SOI    = 8'hD8;
    localparam logic [7:0] MK_SOS    = 8'hDA;
    localparam logic [7:0] MK_SOF0   = 8'hC0;
    localparam logic [7:0] MK_COM    = 8'hFE;
    localparam logic [7:0] MK_APP0   = 8'hE0;
    localparam logic [7:0] MK_APP2   = 8'hE2;

    localparam logic [7:0]  LIMIT_RESET   = 8'd254;
    localparam logic [15:0] SOF0_MIN_PAY  = 16'd5;
    localparam logic [15:0] APP0_MIN_PAY  = 16'd12;
    localparam logic [3:0]  FIELD_POS_MAX = 4'd15;

    typedef struct packed {
        t_phase      phase;
        logic [7:0]  marker;
        logic [15:0] bytes_left;
        logic [3:0]  field_pos;
        logic [7:0]  held_high;
        logic [15:0] held_first;
        logic [7:0]  held_unit;
        logic [7:0]  comment_count;
        logic        icc;
    } t_state;

    localparam t_state ST_RESET = '{
        phase:         PH_SOI0,
        marker:        8'd0,
        bytes_left:    16'd0,
        field_pos:     4'd0,
        held_high:     8'd0,
        held_first:    16'd0,
        held_unit:     8'd0,
        comment_count: 8'd0,
        icc:           1'b0
    };

    typedef struct packed {
        logic [2:0]  event_res;
        logic [7:0]  marker_code;
        logic [15:0] value_a;
        logic [15:0] value_b;
        logic [7:0]  density_unit;
        logic        icc_seen;
        logic        comment_kept;
        logic        comment_last;
    } t_result;

endpackage

>>> design/jsh_if.sv
`timescale 1ns / 1ps

interface jsh_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       start_of_file;

    modport source (output valid, output data_byte, output start_of_file, input ready);
    modport sink (input valid, input data_byte, input start_of_file, output ready);
endinterface

interface jsh_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  event_res;
    logic [7:0]  marker_code;
    logic [15:0] value_a;
    logic [15:0] value_b;
    logic [7:0]  density_unit;
    logic        icc_seen;
    logic        comment_kept;
    logic        comment_last;

    modport source (
        output valid, output event_res, output marker_code, output value_a,
        output value_b, output density_unit, output icc_seen, output comment_kept,
        output comment_last, input ready
    );
    modport sink (
        input valid, input event_res, input marker_code, input value_a,
        input value_b, input density_unit, input icc_seen, input comment_kept,
        input comment_last, output ready
    );
endinterface

interface jsh_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

>>> design/jsh_step.sv
`timescale 1ns / 1ps

module jsh_step
    import jsh_pkg::*;
(
    input  t_state     i_state,
    input  logic [7:0] i_data_byte,
    input  logic       i_start_of_file,
    input  logic [7:0] i_comment_limit,
    output t_state     o_state,
    output logic       o_res_valid,
    output t_result    o_res
);

    t_state      cur;
    t_state      nxt;
    t_result     res;
    logic        res_valid;
    logic [15:0] seg_len;
    logic [15:0] pay;
    logic        kept;

    always_comb begin
        cur = i_state;
        if (i_start_of_file) begin
            cur = ST_RESET;
        end
        nxt       = cur;
        res       = '0;
        res_valid = 1'b0;
        seg_len   = {cur.held_high, i_data_byte};
        pay       = (seg_len >= 16'd2) ? seg_len - 16'd2 : 16'd0;
        // never skip back over the fixed fields
        if (cur.marker == MK_SOF0 && pay < SOF0_MIN_PAY) begin
            pay = SOF0_MIN_PAY;
        end
        if (cur.marker == MK_APP0 && pay < APP0_MIN_PAY) begin
            pay = APP0_MIN_PAY;
        end
        kept = (i_data_byte != 8'd0) && (cur.comment_count < i_comment_limit);

        case (cur.phase)
            PH_SOI0: begin
                if (i_data_byte != MK_PREFIX) begin
                    nxt.phase       = PH_STOP;
                    res_valid       = 1'b1;
                    res.event_res   = EV_NOT_JPEG;
                    res.marker_code = i_data_byte;
                end else begin
                    nxt.phase = PH_SOI1;
                end
            end
            PH_SOI1: begin
                res_valid = 1'b1;
                if (i_data_byte != MK_SOI) begin
                    nxt.phase       = PH_STOP;
                    res.event_res   = EV_NOT_JPEG;
                    res.marker_code = i_data_byte;
                end else begin
                    nxt.phase       = PH_MARK1;
                    res.event_res   = EV_MARKER;
                    res.marker_code = MK_SOI;
                end
            end
            PH_MARK1: begin
                if (i_data_byte != MK_PREFIX) begin
                    nxt.phase       = PH_STOP;
                    res_valid       = 1'b1;
                    res.event_res   = EV_BAD_PREFIX;
                    res.marker_code = i_data_byte;
                end else begin
                    nxt.phase = PH_MARK2;
                end
            end
            PH_MARK2: begin
                nxt.marker = i_data_byte;
                if (i_data_byte == MK_APP2) begin
                    nxt.icc = 1'b1;
                end
                nxt.phase       = (i_data_byte == MK_SOS) ? PH_STOP : PH_LENH;
                res_valid       = 1'b1;
                res.event_res   = EV_MARKER;
                res.marker_code = i_data_byte;
            end
            PH_LENH: begin
                nxt.held_high = i_data_byte;
                nxt.phase     = PH_LENL;
            end
            PH_LENL: begin
                nxt.bytes_left = pay;
                nxt.field_pos  = 4'd0;
                if (cur.marker == MK_COM) begin
                    nxt.comment_count = 8'd0;
                end
                if (pay == 16'd0) begin
                    nxt.phase = PH_MARK1;
                    if (cur.marker == MK_COM) begin
                        // empty comment still reports one closing byte
                        res_valid        = 1'b1;
                        res.event_res    = EV_COMMENT;
                        res.marker_code  = MK_COM;
                        res.comment_last = 1'b1;
                    end
                end else begin
                    nxt.phase = PH_BODY;
                end
            end
            PH_BODY: begin
                nxt.bytes_left = cur.bytes_left - 16'd1;
                if (cur.field_pos != FIELD_POS_MAX) begin
                    nxt.field_pos = cur.field_pos + 4'd1;
                end
                if (nxt.bytes_left == 16'd0) begin
                    nxt.phase = PH_MARK1;
                end
                if (cur.marker == MK_SOF0) begin
                    if (cur.field_pos == 4'd1 || cur.field_pos == 4'd3) begin
                        nxt.held_high = i_data_byte;
                    end else if (cur.field_pos == 4'd2) begin
                        nxt.held_first = {cur.held_high, i_data_byte};
                    end else if (cur.field_pos == 4'd4) begin
                        res_valid       = 1'b1;
                        res.event_res   = EV_FRAME_SIZE;
                        res.marker_code = MK_SOF0;
                        res.value_a     = cur.held_first;
                        res.value_b     = {cur.held_high, i_data_byte};
                    end
                end else if (cur.marker == MK_APP0) begin
                    if (cur.field_pos == 4'd7) begin
                        nxt.held_unit = i_data_byte;
                    end else if (cur.field_pos == 4'd8 || cur.field_pos == 4'd10) begin
                        nxt.held_high = i_data_byte;
                    end else if (cur.field_pos == 4'd9) begin
                        nxt.held_first = {cur.held_high, i_data_byte};
                    end else if (cur.field_pos == 4'd11) begin
                        res_valid        = 1'b1;
                        res.event_res    = EV_DENSITY;
                        res.marker_code  = MK_APP0;
                        res.value_a      = cur.held_first;
                        res.value_b      = {cur.held_high, i_data_byte};
                        res.density_unit = cur.held_unit;
                    end
                end else if (cur.marker == MK_COM) begin
                    if (kept) begin
                        nxt.comment_count = cur.comment_count + 8'd1;
                    end
                    res_valid        = 1'b1;
                    res.event_res    = EV_COMMENT;
                    res.marker_code  = MK_COM;
                    res.value_a      = {8'd0, i_data_byte};
                    res.comment_kept = kept;
                    res.comment_last = (nxt.bytes_left == 16'd0);
                end
            end
            PH_STOP: begin
                nxt.phase = PH_STOP;
            end
            default: begin
                nxt.phase = PH_STOP;
            end
        endcase
        res.icc_seen = nxt.icc;
    end

    assign o_state     = nxt;
    assign o_res_valid = res_valid;
    assign o_res       = res;

endmodule

>>> design/jpeg_segment_header_parser_unit.sv
`timescale 1ns / 1ps
// channel   dir  handshake     payload
// i_in      in   valid/ready   data_byte[7:0], start_of_file
// o_out     out  valid/ready   event_res[2:0], marker_code, value_a, value_b,
//                              density_unit, icc_seen, comment_kept, comment_last
// i_cfg     in   valid/ready   data[7:0] -> comment_limit (ready always high)
//
// one byte per cycle while input ready is high; a result appears the cycle after its byte is taken
// the parse state update is one combinational step into the state and result registers
// input ready is high while the result register is empty or being drained
// i_rst_n (synchronous) sets comment_limit to 254 and the parser to expect FF D8

module jpeg_segment_header_parser_unit
    import jsh_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    jsh_in_if.sink   i_in,
    jsh_cfg_if.sink  i_cfg,
    jsh_out_if.source o_out
);

    t_state     r_state;
    t_state     n_state;
    t_result    r_res;
    t_result    n_res;
    logic       n_res_valid;
    logic       r_out_valid;
    logic [7:0] r_comment_limit;
    logic       in_ready;
    logic       in_acc;

    assign in_ready    = !r_out_valid || o_out.ready;
    assign in_acc      = i_in.valid && in_ready;
    assign i_in.ready  = in_ready;
    assign i_cfg.ready = 1'b1;

    jsh_step u_step (
        .i_state         (r_state),
        .i_data_byte     (i_in.data_byte),
        .i_start_of_file (i_in.start_of_file),
        .i_comment_limit (r_comment_limit),
        .o_state         (n_state),
        .o_res_valid     (n_res_valid),
        .o_res           (n_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= ST_RESET;
            r_out_valid     <= 1'b0;
            r_comment_limit <= LIMIT_RESET;
        end else begin
            if (i_cfg.valid) begin
                r_comment_limit <= i_cfg.data;
            end
            if (in_acc) begin
                r_state     <= n_state;
                r_out_valid <= n_res_valid;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && n_res_valid) begin
            r_res <= n_res;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.event_res    = r_res.event_res;
    assign o_out.marker_code  = r_res.marker_code;
    assign o_out.value_a      = r_res.value_a;
    assign o_out.value_b      = r_res.value_b;
    assign o_out.density_unit = r_res.density_unit;
    assign o_out.icc_seen     = r_res.icc_seen;
    assign o_out.comment_kept = r_res.comment_kept;
    assign o_out.comment_last = r_res.comment_last;

    // a file that does not open with the prefix byte is rejected at once
    a_not_jpeg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && i_in.start_of_file && i_in.data_byte != MK_PREFIX
        |=> o_out.valid && o_out.event_res == EV_NOT_JPEG)
        else $error("non-jpeg first byte not reported");

    // once stopped, bytes give nothing until a restart
    a_stop_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && !i_in.start_of_file && r_state.phase == PH_STOP
        |=> !o_out.valid)
        else $error("result produced while stopped");

    // kept and last flags only ride on comment results
    a_comment_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && (o_out.comment_kept || o_out.comment_last)
        |-> o_out.event_res == EV_COMMENT && o_out.marker_code == MK_COM)
        else $error("comment flag on non-comment result");

endmodule

>>> tb/sv/jsh_event_checker.sv
`timescale 1ns / 1ps

module jsh_event_checker
    import jsh_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [7:0]  i_in_data_byte,
    input  logic        i_in_start_of_file,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [7:0]  i_cfg_data,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [2:0]  i_out_event_res,
    input  logic [7:0]  i_out_marker_code,
    input  logic [15:0] i_out_value_a,
    input  logic [15:0] i_out_value_b,
    input  logic [7:0]  i_out_density_unit,
    input  logic        i_out_icc_seen,
    input  logic        i_out_comment_kept,
    input  logic        i_out_comment_last,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_bytes_seen,
    output int          o_results_seen
);

    t_state     walk_st;
    logic [7:0] comment_cap;
    t_result    pending_events[$];
    int         fail_count = 0;
    int         bytes_seen = 0;
    int         results_seen = 0;

    assign o_fail_count   = fail_count;
    assign o_bytes_seen   = bytes_seen;
    assign o_results_seen = results_seen;

    task automatic report_mismatch(input string msg);
        fail_count++;
        if (fail_count <= 30) begin
            $display("ERROR at %0t, result %0d: %s", $realtime, results_seen, msg);
        end
    endtask

    task automatic check_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("%s is 0x%0h, expected 0x%0h", name, got, want));
        end
    endtask

    // icc_seen always reflects the flag as it stands once the byte is handled
    function automatic t_result make_event(input logic [2:0] ev, input logic [7:0] code,
                                           input logic [15:0] a, input logic [15:0] b,
                                           input logic [7:0] unit, input logic kept,
                                           input logic last);
        t_result r;
        r.event_res    = ev;
        r.marker_code  = code;
        r.value_a      = a;
        r.value_b      = b;
        r.density_unit = unit;
        r.icc_seen     = walk_st.icc;
        r.comment_kept = kept;
        r.comment_last = last;
        return r;
    endfunction

    task automatic walk_byte(input logic [7:0] b, input logic sof,
                             output logic has_event, output t_result ev);
        logic [15:0] len;
        logic [15:0] pay;
        logic [3:0]  pos;
        logic        kept;
        has_event = 1'b0;
        ev = '0;
        if (sof) begin
            walk_st = ST_RESET;
        end
        case (walk_st.phase)
            PH_SOI0: begin
                if (b != MK_PREFIX) begin
                    walk_st.phase = PH_STOP;
                    has_event = 1'b1;
                    ev = make_event(EV_NOT_JPEG, b, 16'd0, 16'd0, 8'd0, 1'b0, 1'b0);
                end else begin
                    walk_st.phase = PH_SOI1;
                end
            end
            PH_SOI1: begin
                has_event = 1'b1;
                if (b != MK_SOI) begin
                    walk_st.phase = PH_STOP;
                    ev = make_event(EV_NOT_JPEG, b, 16'd0, 16'd0, 8'd0, 1'b0, 1'b0);
                end else begin
                    walk_st.phase = PH_MARK1;
                    ev = make_event(EV_MARKER, MK_SOI, 16'd0, 16'd0, 8'd0, 1'b0, 1'b0);
                end
            end
            PH_MARK1: begin
                if (b != MK_PREFIX) begin
                    walk_st.phase = PH_STOP;
                    has_event = 1'b1;
                    ev = make_event(EV_BAD_PREFIX, b, 16'd0, 16'd0, 8'd0, 1'b0, 1'b0);
                end else begin
                    walk_st.phase = PH_MARK2;
                end
            end
            PH_MARK2: begin
                walk_st.marker = b;
                if (b == MK_APP2) begin
                    walk_st.icc = 1'b1;
                end
                walk_st.phase = (b == MK_SOS) ? PH_STOP : PH_LENH;
                has_event = 1'b1;
                ev = make_event(EV_MARKER, b, 16'd0, 16'd0, 8'd0, 1'b0, 1'b0);
            end
            PH_LENH: begin
                walk_st.held_high = b;
                walk_st.phase = PH_LENL;
            end
            PH_LENL: begin
                len = {walk_st.held_high, b};
                pay = (len >= 16'd2) ? len - 16'd2 : 16'd0;
                // short lengths on SOF0 and APP0 still cover their fixed fields
                if (walk_st.marker == MK_SOF0 && pay < SOF0_MIN_PAY) begin
                    pay = SOF0_MIN_PAY;
                end
                if (walk_st.marker == MK_APP0 && pay < APP0_MIN_PAY) begin
                    pay = APP0_MIN_PAY;
                end
                walk_st.bytes_left = pay;
                walk_st.field_pos = 4'd0;
                if (walk_st.marker == MK_COM) begin
                    walk_st.comment_count = 8'd0;
                end
                if (pay == 16'd0) begin
                    walk_st.phase = PH_MARK1;
                    if (walk_st.marker == MK_COM) begin
                        has_event = 1'b1;
                        ev = make_event(EV_COMMENT, MK_COM, 16'd0, 16'd0, 8'd0, 1'b0, 1'b1);
                    end
                end else begin
                    walk_st.phase = PH_BODY;
                end
            end
            PH_BODY: begin
                pos = walk_st.field_pos;
                walk_st.bytes_left = walk_st.bytes_left - 16'd1;
                if (walk_st.field_pos < FIELD_POS_MAX) begin
                    walk_st.field_pos = walk_st.field_pos + 4'd1;
                end
                if (walk_st.bytes_left == 16'd0) begin
                    walk_st.phase = PH_MARK1;
                end
                if (walk_st.marker == MK_SOF0) begin
                    if (pos == 4'd1 || pos == 4'd3) begin
                        walk_st.held_high = b;
                    end else if (pos == 4'd2) begin
                        walk_st.held_first = {walk_st.held_high, b};
                    end else if (pos == 4'd4) begin
                        has_event = 1'b1;
                        ev = make_event(EV_FRAME_SIZE, MK_SOF0, walk_st.held_first,
                                        {walk_st.held_high, b}, 8'd0, 1'b0, 1'b0);
                    end
                end else if (walk_st.marker == MK_APP0) begin
                    if (pos == 4'd7) begin
                        walk_st.held_unit = b;
                    end else if (pos == 4'd8 || pos == 4'd10) begin
                        walk_st.held_high = b;
                    end else if (pos == 4'd9) begin
                        walk_st.held_first = {walk_st.held_high, b};
                    end else if (pos == 4'd11) begin
                        has_event = 1'b1;
                        ev = make_event(EV_DENSITY, MK_APP0, walk_st.held_first,
                                        {walk_st.held_high, b}, walk_st.held_unit,
                                        1'b0, 1'b0);
                    end
                end else if (walk_st.marker == MK_COM) begin
                    kept = (b != 8'd0) && (walk_st.comment_count < comment_cap);
                    if (kept) begin
                        walk_st.comment_count = walk_st.comment_count + 8'd1;
                    end
                    has_event = 1'b1;
                    ev = make_event(EV_COMMENT, MK_COM, {8'd0, b}, 16'd0, 8'd0, kept,
                                    walk_st.bytes_left == 16'd0);
                end
            end
            default: begin
            end
        endcase
    endtask

    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        t_result predicted;
        logic    has_event;
        if (!i_rst_n) begin
            walk_st = ST_RESET;
            comment_cap = LIMIT_RESET;
            pending_events.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                results_seen++;
                got = {i_out_event_res, i_out_marker_code, i_out_value_a, i_out_value_b,
                       i_out_density_unit, i_out_icc_seen, i_out_comment_kept,
                       i_out_comment_last};
                if (pending_events.size() == 0) begin
                    report_mismatch($sformatf("result event %0d code 0x%0h with none expected",
                                              got.event_res, got.marker_code));
                end else begin
                    want = pending_events.pop_front();
                    check_field("event_res", 16'(got.event_res), 16'(want.event_res));
                    check_field("marker_code", 16'(got.marker_code), 16'(want.marker_code));
                    check_field("value_a", got.value_a, want.value_a);
                    check_field("value_b", got.value_b, want.value_b);
                    check_field("density_unit", 16'(got.density_unit),
                                16'(want.density_unit));
                    check_field("icc_seen", 16'(got.icc_seen), 16'(want.icc_seen));
                    check_field("comment_kept", 16'(got.comment_kept),
                                16'(want.comment_kept));
                    check_field("comment_last", 16'(got.comment_last),
                                16'(want.comment_last));
                end
            end
            // a request taken at the same edge as a limit write still sees the old limit
            if (i_in_valid && i_in_ready) begin
                bytes_seen++;
                walk_byte(i_in_data_byte, i_in_start_of_file, has_event, predicted);
                if (has_event) begin
                    pending_events.push_back(predicted);
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                comment_cap = i_cfg_data;
            end
        end
        o_pending = pending_events.size();
    end

endmodule

>>> tb/sv/jpeg_segment_header_parser_unit_test.sv
`timescale 1ns / 1ps

module jpeg_segment_header_parser_unit_test;
    import jsh_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_LEN    = 80;
    localparam int PHASE_BYTES = 240;

    logic i_clk;
    logic i_rst_n;

    jsh_in_if  in_ch();
    jsh_out_if out_ch();
    jsh_cfg_if cfg_ch();

    int chk_fails;
    int chk_pending;
    int chk_bytes;
    int chk_results;

    int send_idle_pct = 0;
    int stall_pct = 0;
    int hold_requests = 0;
    int files_sent = 0;
    int cycle_count = 0;

    logic [8:0] file_q[$];   // {start_of_file, data_byte}

    jpeg_segment_header_parser_unit u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .i_cfg   (cfg_ch),
        .o_out   (out_ch)
    );

    jsh_event_checker u_checker (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (in_ch.valid),
        .i_in_ready         (in_ch.ready),
        .i_in_data_byte     (in_ch.data_byte),
        .i_in_start_of_file (in_ch.start_of_file),
        .i_cfg_valid        (cfg_ch.valid),
        .i_cfg_ready        (cfg_ch.ready),
        .i_cfg_data         (cfg_ch.data),
        .i_out_valid        (out_ch.valid),
        .i_out_ready        (out_ch.ready),
        .i_out_event_res    (out_ch.event_res),
        .i_out_marker_code  (out_ch.marker_code),
        .i_out_value_a      (out_ch.value_a),
        .i_out_value_b      (out_ch.value_b),
        .i_out_density_unit (out_ch.density_unit),
        .i_out_icc_seen     (out_ch.icc_seen),
        .i_out_comment_kept (out_ch.comment_kept),
        .i_out_comment_last (out_ch.comment_last),
        .o_fail_count       (chk_fails),
        .o_pending          (chk_pending),
        .o_bytes_seen       (chk_bytes),
        .o_results_seen     (chk_results)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles", cycle_count);
        $display("FAILURE");
        $finish;
    end

    // result side: random stalls, plus long hold-offs on request
    initial begin
        int holds_served;
        int hold_left;
        holds_served = 0;
        hold_left = 0;
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (holds_served != hold_requests) begin
                holds_served++;
                hold_left = HOLD_LEN;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ch.ready = 1'b0;
            end else begin
                out_ch.ready = ($urandom_range(99) >= stall_pct);
            end
        end
    end

    function automatic logic [7:0] rand_byte();
        return 8'($urandom_range(255));
    endfunction

    task automatic put(input logic [7:0] b);
        file_q.push_back({file_q.size() == 0, b});
    endtask

    task automatic push_byte(input logic [7:0] b, input logic sof);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid = 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid = 1'b1;
        in_ch.data_byte = b;
        in_ch.start_of_file = sof;
        do @(posedge i_clk); while (!in_ch.ready);
    endtask

    task automatic send_file();
        foreach (file_q[i]) begin
            push_byte(file_q[i][7:0], file_q[i][8]);
        end
        file_q.delete();
        files_sent++;
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        in_ch.valid = 1'b0;
        while (chk_pending != 0) @(negedge i_clk);
        // bytes that make no result may still be in the block
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_limit(input logic [7:0] limit);
        @(negedge i_clk);
        cfg_ch.valid = 1'b1;
        cfg_ch.data = limit;
        do @(posedge i_clk); while (!cfg_ch.ready);
        @(negedge i_clk);
        cfg_ch.valid = 1'b0;
    endtask

    task automatic put_segment(input logic [7:0] code);
        int          pay;
        int          body;
        logic [15:0] len;
        logic        long_com;
        if (code == MK_SOF0) begin
            pay = $urandom_range(5, 17);
        end else if (code == MK_APP0) begin
            pay = $urandom_range(12, 20);
        end else if (code == MK_COM) begin
            pay = ($urandom_range(29) == 0) ? $urandom_range(256, 300) : $urandom_range(40);
        end else begin
            pay = $urandom_range(24);
        end
        long_com = (pay > 255);
        len = 16'(pay + 2);
        if ($urandom_range(7) == 0) begin
            len = 16'($urandom_range(6));
        end
        put(MK_PREFIX);
        put(code);
        put(len[15:8]);
        put(len[7:0]);
        body = (len >= 16'd2) ? int'(len) - 2 : 0;
        if (code == MK_SOF0 && body < 5) body = 5;
        if (code == MK_APP0 && body < 12) body = 12;
        repeat (body) begin
            if (code == MK_COM && $urandom_range(long_com ? 49 : 4) == 0) begin
                put(8'h00);
            end else begin
                put(rand_byte());
            end
        end
    endtask

    task automatic build_file();
        int         kind;
        int         r;
        logic [7:0] code;
        kind = $urandom_range(99);
        if (kind < 5) begin
            put(8'($urandom_range(254)));
            repeat ($urandom_range(3)) put(rand_byte());
        end else if (kind < 10) begin
            code = rand_byte();
            if (code == MK_SOI) code = 8'h00;
            put(MK_PREFIX);
            put(code);
            repeat ($urandom_range(3)) put(rand_byte());
        end else begin
            put(MK_PREFIX);
            put(MK_SOI);
            repeat ($urandom_range(1, 6)) begin
                r = $urandom_range(99);
                if (r < 20) code = MK_SOF0;
                else if (r < 35) code = MK_APP0;
                else if (r < 55) code = MK_COM;
                else if (r < 65) code = MK_APP2;
                else if (r < 72) code = 8'hE1;
                else if (r < 76) code = MK_PREFIX;
                else if (r < 80) code = MK_SOI;
                else if (r < 84) code = 8'hD9;
                else if (r < 88) code = 8'(8'hD0 + $urandom_range(7));
                else begin
                    code = rand_byte();
                    if (code == MK_SOS) code = 8'h01;
                end
                put_segment(code);
            end
            r = $urandom_range(99);
            if (r < 70) begin
                put(MK_PREFIX);
                put(MK_SOS);
                repeat ($urandom_range(3)) put(rand_byte());
            end else if (r < 85) begin
                put(8'($urandom_range(254)));
            end else begin
                // cut off inside a segment header or body, next file restarts
                put(MK_PREFIX);
                repeat ($urandom_range(1, 7)) put(rand_byte());
            end
        end
    endtask

    task automatic send_files(input int byte_goal, input logic with_holds);
        int start;
        int nfiles;
        start = chk_bytes;
        nfiles = 0;
        while (chk_bytes - start < byte_goal) begin
            if (with_holds && nfiles % 3 == 1) begin
                hold_requests++;
            end
            build_file();
            send_file();
            nfiles++;
        end
    endtask

    task automatic send_directed();
        put(8'h00);
        send_file();
        put(MK_PREFIX);
        put(8'h00);
        send_file();
        put(MK_PREFIX);
        put(MK_SOI);
        // empty comment from a zero length
        put(MK_PREFIX);
        put(MK_COM);
        put(8'h00);
        put(8'h00);
        // zero length on SOF0 still walks five bytes, largest height and width
        put(MK_PREFIX);
        put(MK_SOF0);
        put(8'h00);
        put(8'h00);
        repeat (5) put(8'hFF);
        // missing prefix stops the walk, the following prefix is ignored
        put(8'h12);
        put(MK_PREFIX);
        send_file();
        put(MK_PREFIX);
        put(MK_SOI);
        put(MK_PREFIX);
        put(MK_APP2);
        put(8'h00);
        put(8'h02);
        put(MK_PREFIX);
        put(MK_SOS);
        send_file();
    endtask

    initial begin
        int phase_limit[5];
        int phase_idle[5];
        int phase_stall[5];
        int phase_hold[5];
        in_ch.valid = 1'b0;
        in_ch.data_byte = 8'd0;
        in_ch.start_of_file = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.data = 8'd0;
        i_rst_n = 1'b0;
        phase_limit = '{0, 255, 1, $urandom_range(2, 253), 3};
        phase_idle  = '{0, 85, 0, 22, 0};
        phase_stall = '{0, 0, 85, 22, 0};
        phase_hold  = '{0, 0, 0, 0, 1};
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        send_directed();
        for (int p = 0; p < 5; p++) begin
            wait_drained();
            send_idle_pct = phase_idle[p];
            stall_pct = phase_stall[p];
            write_limit(8'(phase_limit[p]));
            send_files(PHASE_BYTES, phase_hold[p] != 0);
        end
        wait_drained();
        repeat (8) @(negedge i_clk);

        $display("run covered %0d bytes in %0d files, %0d results checked",
                 chk_bytes, files_sent, chk_results);
        $display("comment limits reset, 0, 255, 1, %0d, 3; idle, stall and hold-off phases",
                 phase_limit[3]);
        if (chk_fails == 0 && chk_pending == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

>>> filelist.f
design/jsh_pkg.sv
design/jsh_if.sv
design/jsh_step.sv
design/jpeg_segment_header_parser_unit.sv
tb/sv/jsh_event_checker.sv
tb/sv/jpeg_segment_header_parser_unit_test.sv
